FILE: sv/bcdar_pkg.sv
// Shared types, constants and helpers of the BCD adder and reverse lookup block.
// No dependencies; used by bcdar_table and bcd_add_and_reverse_lookup_regs.
package bcdar_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int TBL_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef logic [TBL_IDX_W-1:0] tbl_idx_type;

   localparam tbl_idx_type TBL_LAST    = TBL_IDX_W'(TABLE_DEPTH - 1);
   localparam logic [8:0]  TBL_DEPTH_9 = 9'(TABLE_DEPTH);

   // Bus window offsets
   localparam logic [11:0] OFS_TRIGGER      = 12'h000;
   localparam logic [11:0] OFS_COMMAND      = 12'hC00;
   localparam logic [11:0] OFS_OPERAND      = 12'hD00;
   localparam logic [11:0] OFS_SUM_LAST     = 12'hD02;
   localparam logic [11:0] OFS_OPERAND_LAST = 12'hD05;
   localparam logic [11:0] OFS_KEY          = 12'hE00;
   localparam logic [3:0]  TABLE_PAGE       = 4'hF;

   // Commands
   localparam logic [7:0] CMD_ADD    = 8'd0;
   localparam logic [7:0] CMD_SEARCH = 8'd1;

   localparam int         NUM_DIGITS = 6;
   localparam logic [2:0] LAST_DIGIT = 3'(NUM_DIGITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic        en;
      tbl_idx_type idx;
      logic [7:0]  data;
   } tbl_wr_type;

   typedef struct packed {
      logic [1:0] carry;
      logic [3:0] digit;
   } digit_type;

   // Split a column sum (at most 15 + 15 + 3) into a decimal digit and carry
   function automatic digit_type digit_split(input logic [5:0] t);
      digit_type r;
      if (t >= 6'd30) begin
         r.carry = 2'd3;
         r.digit = 4'(t - 6'd30);
      end else if (t >= 6'd20) begin
         r.carry = 2'd2;
         r.digit = 4'(t - 6'd20);
      end else if (t >= 6'd10) begin
         r.carry = 2'd1;
         r.digit = 4'(t - 6'd10);
      end else begin
         r.carry = 2'd0;
         r.digit = t[3:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/bcd_add_and_reverse_lookup_regs.sv
// Bus-mapped co-processor: packed-BCD adder and reverse table lookup.
// Depends on bcdar_pkg and bcdar_table.
//
// Every bus transfer gives exactly one response byte; a read or an ordinary
// write is answered in the cycle after it is taken. A trigger write (zero to
// offset 0) is also answered at once, but then keeps req_stall high while the
// command runs: the add walks the six digits through one shared digit adder,
// one digit a cycle; the search reads the table through its single registered
// read port, one entry a cycle, and stops at the first match or after the last
// entry. The table's reset state comes from per-entry valid bits, so there is
// no clearing pass.
module bcd_add_and_reverse_lookup_regs (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data
);

   bcdar_pkg::state_type   state_ff, state_in;
   logic [7:0]             command_ff, command_in;
   logic [7:0]             key_ff, key_in;
   logic [7:0]             found_ff, found_in;
   logic [23:0]            op_a_ff, op_a_in;
   logic [23:0]            op_b_ff, op_b_in;
   logic [2:0]             dig_ff, dig_in;
   logic [1:0]             carry_ff, carry_in;
   bcdar_pkg::tbl_idx_type scan_idx_ff, scan_idx_in;
   bcdar_pkg::tbl_idx_type cmp_idx_ff, cmp_idx_in;
   logic                   cmp_pend_ff, cmp_pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   is_wr;
   logic                   trig;
   logic                   start_add;
   logic                   start_scan;
   logic                   in_operand;
   logic                   in_sum;
   logic [5:0]             col_sum;
   bcdar_pkg::digit_type   col_res;
   logic                   match;
   logic                   scan_done;
   logic [7:0]             rd_val;
   logic                   tbl_rd_en;
   logic [7:0]             tbl_rd_data;
   bcdar_pkg::tbl_wr_type  tbl_wr;

   bcdar_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_en   (tbl_rd_en),
      .rd_idx  (scan_idx_ff),
      .rd_data (tbl_rd_data)
   );

   // Decode
   assign accept     = req_valid && !req_stall;
   assign is_wr      = accept && req_opcode;
   assign trig       = is_wr && (req_address == bcdar_pkg::OFS_TRIGGER)
                       && (req_write_data == 8'd0);
   assign start_add  = trig && (command_ff == bcdar_pkg::CMD_ADD);
   assign start_scan = trig && (command_ff == bcdar_pkg::CMD_SEARCH);
   assign in_operand = (req_address >= bcdar_pkg::OFS_OPERAND)
                       && (req_address <= bcdar_pkg::OFS_OPERAND_LAST);
   assign in_sum     = (req_address >= bcdar_pkg::OFS_OPERAND)
                       && (req_address <= bcdar_pkg::OFS_SUM_LAST);

   // Shared digit adder: always works on the low nibbles
   assign col_sum = 6'(op_a_ff[3:0]) + 6'(op_b_ff[3:0]) + 6'(carry_ff);
   assign col_res = bcdar_pkg::digit_split(col_sum);

   assign match     = cmp_pend_ff && (tbl_rd_data == key_ff);
   assign scan_done = cmp_pend_ff && (match || (cmp_idx_ff == bcdar_pkg::TBL_LAST));

   always_comb begin
      tbl_wr.en   = is_wr && (req_address[11:8] == bcdar_pkg::TABLE_PAGE)
                    && ({1'b0, req_address[7:0]} < bcdar_pkg::TBL_DEPTH_9);
      tbl_wr.idx  = req_address[bcdar_pkg::TBL_IDX_W-1:0];
      tbl_wr.data = req_write_data;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcdar_pkg::ST_IDLE: begin
            if (start_add) begin
               state_in = bcdar_pkg::ST_ADD;
            end else if (start_scan) begin
               state_in = bcdar_pkg::ST_SCAN;
            end
         end
         bcdar_pkg::ST_ADD: begin
            if (dig_ff == bcdar_pkg::LAST_DIGIT) begin
               state_in = bcdar_pkg::ST_IDLE;
            end
         end
         bcdar_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = bcdar_pkg::ST_IDLE;
            end
         end
         default: state_in = bcdar_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      tbl_rd_en = 1'b0;
      case (state_ff)
         bcdar_pkg::ST_IDLE: req_stall = rsp_valid_ff && rsp_stall;
         bcdar_pkg::ST_ADD:  req_stall = 1'b1;
         bcdar_pkg::ST_SCAN: tbl_rd_en = (scan_idx_ff <= bcdar_pkg::TBL_LAST);
         default:            req_stall = 1'b1;
      endcase
   end

   // Read mux
   always_comb begin
      rd_val = 8'd0;
      if (req_address == bcdar_pkg::OFS_TRIGGER) begin
         rd_val = 8'd0;
      end else if (req_address == bcdar_pkg::OFS_KEY) begin
         rd_val = found_ff;
      end else if (in_sum) begin
         case (req_address[1:0])
            2'd0:    rd_val = op_a_ff[7:0];
            2'd1:    rd_val = op_a_ff[15:8];
            2'd2:    rd_val = op_a_ff[23:16];
            default: rd_val = 8'd0;
         endcase
      end
   end

   // Datapath
   always_comb begin
      command_in   = command_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      dig_in       = dig_ff;
      carry_in     = carry_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_idx_in   = scan_idx_ff;
      cmp_pend_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (is_wr && (req_address == bcdar_pkg::OFS_COMMAND)) begin
         command_in = req_write_data;
      end
      if (is_wr && (req_address == bcdar_pkg::OFS_KEY)) begin
         key_in = req_write_data;
      end

      if (state_ff == bcdar_pkg::ST_ADD) begin
         // Rotate both operands a digit; the sum digit enters at the top of A
         op_a_in  = {col_res.digit, op_a_ff[23:4]};
         op_b_in  = {op_b_ff[3:0], op_b_ff[23:4]};
         carry_in = col_res.carry;
         dig_in   = dig_ff + 3'd1;
      end else if (is_wr && in_operand) begin
         case (req_address[2:0])
            3'd0:    op_a_in[7:0]   = req_write_data;
            3'd1:    op_a_in[15:8]  = req_write_data;
            3'd2:    op_a_in[23:16] = req_write_data;
            3'd3:    op_b_in[7:0]   = req_write_data;
            3'd4:    op_b_in[15:8]  = req_write_data;
            3'd5:    op_b_in[23:16] = req_write_data;
            default: op_a_in        = op_a_ff;
         endcase
      end

      if (start_add) begin
         dig_in   = 3'd0;
         carry_in = 2'd0;
      end

      if (start_scan) begin
         scan_idx_in = '0;
      end else if (state_ff == bcdar_pkg::ST_SCAN) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         cmp_pend_in = !scan_done;
         if (match) begin
            found_in = 8'(cmp_idx_ff);
         end
      end

      // Free the output register on transfer, then load the new response
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = req_opcode ? 8'd0 : rd_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcdar_pkg::ST_IDLE;
         command_ff   <= 8'd0;
         key_ff       <= 8'd0;
         found_ff     <= 8'd0;
         op_a_ff      <= 24'd0;
         op_b_ff      <= 24'd0;
         cmp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         command_ff   <= command_in;
         key_ff       <= key_in;
         found_ff     <= found_in;
         op_a_ff      <= op_a_in;
         op_b_ff      <= op_b_in;
         cmp_pend_ff  <= cmp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      carry_ff    <= carry_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bcdar_pkg::ST_IDLE) |-> req_stall)
      else $error("request taken while a command runs");

   a_found_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      !$stable(found_ff) |-> ($past(state_ff) == bcdar_pkg::ST_SCAN || $past(reset)))
      else $error("answer changed outside a search");

   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bcdar_pkg::ST_IDLE) |=> !$rose(rsp_valid_ff))
      else $error("response loaded while a command runs");
`endif

endmodule

FILE: sv/bcdar_table.sv
// Lookup table store: one write port, one registered read port, per-entry valid bits.
// Depends on bcdar_pkg for the depth, index type and write struct.
module bcdar_table (
   input  logic                    clock,
   input  logic                    reset,
   input  bcdar_pkg::tbl_wr_type   wr,
   input  logic                    rd_en,
   input  bcdar_pkg::tbl_idx_type  rd_idx,
   output logic [7:0]              rd_data
);

   logic [7:0]                          mem [bcdar_pkg::TABLE_DEPTH];
   logic [bcdar_pkg::TABLE_DEPTH-1:0]   valid_ff;
   logic [7:0]                          rd_raw_ff;
   logic                                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_raw_ff <= mem[rd_idx];
      end
   end

   // Entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : 8'd0;

endmodule

FILE: bench/tb_bcd_add_and_reverse_lookup_regs.sv
// Self-checking bench for the BCD adder and reverse lookup co-processor.
// Sends byte reads and writes, predicts every response byte in a behavioural
// copy of the registers and compares; depends on bcdar_pkg and the RTL.
module tb_bcd_add_and_reverse_lookup_regs;

   localparam logic        OP_READ      = 1'b0;
   localparam logic        OP_WRITE     = 1'b1;
   localparam logic [11:0] OFS_TABLE    = {bcdar_pkg::TABLE_PAGE, 8'h00};
   localparam int          NUM_ITEMS    = 1600;
   localparam int          IDLE_LIMIT   = 3000;
   localparam int          DRAIN_CYCLES = 300;

   typedef struct packed {
      logic        opcode;
      logic [11:0] address;
      logic [7:0]  write_data;
   } bus_access_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic        req_opcode     = OP_READ;
   logic [11:0] req_address    = 12'h000;
   logic [7:0]  req_write_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [7:0]  rsp_read_data;

   bus_access_type access_q[$];
   logic [7:0]     read_data_q[$];
   bus_access_type next_access;
   logic [7:0]     want_data;
   logic           stall_next;
   int             error_count    = 0;
   int             accepted_count = 0;
   int             total_items    = 0;
   int             gap_left       = 0;
   int             burst_left     = 1;
   int             hold_left      = 0;
   int             flow_left      = 0;
   int             idle_cycles    = 0;

   // Register copy kept by the predictor
   logic [7:0] cur_command;
   logic [7:0] cur_key;
   logic [7:0] cur_found;
   logic [7:0] cur_operand [bcdar_pkg::NUM_DIGITS];
   logic [7:0] cur_table   [bcdar_pkg::TABLE_DEPTH];

   bcd_add_and_reverse_lookup_regs u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Six nibbles at face value, each weighted by its decimal position
   function automatic int unsigned operand_face_value(input int base);
      int unsigned v;
      int unsigned w;
      v = 0;
      w = 1;
      for (int k = 0; k < 3; k++) begin
         v += w * cur_operand[base + k][3:0];
         w *= 10;
         v += w * cur_operand[base + k][7:4];
         w *= 10;
      end
      return v;
   endfunction

   function automatic logic [7:0] predict_read_data(input bus_access_type a);
      int unsigned sum;
      logic [3:0]  lo;
      logic [3:0]  hi;
      logic [11:0] idx;
      bit          hit;
      logic [7:0]  rd;
      rd = 8'h00;
      if (a.opcode == OP_WRITE) begin
         if (a.address == bcdar_pkg::OFS_TRIGGER) begin
            if (a.write_data == 8'h00) begin
               if (cur_command == bcdar_pkg::CMD_ADD) begin
                  sum = operand_face_value(0) + operand_face_value(3);
                  for (int k = 0; k < 3; k++) begin
                     lo = 4'(sum % 10);
                     sum /= 10;
                     hi = 4'(sum % 10);
                     sum /= 10;
                     cur_operand[k] = {hi, lo};
                  end
               end else if (cur_command == bcdar_pkg::CMD_SEARCH) begin
                  hit = 1'b0;
                  for (int i = 0; i < bcdar_pkg::TABLE_DEPTH; i++) begin
                     if (!hit && cur_table[i] == cur_key) begin
                        cur_found = 8'(i);
                        hit = 1'b1;
                     end
                  end
               end
            end
         end else if (a.address == bcdar_pkg::OFS_COMMAND) begin
            cur_command = a.write_data;
         end else if (a.address == bcdar_pkg::OFS_KEY) begin
            cur_key = a.write_data;
         end else if (a.address >= OFS_TABLE) begin
            idx = a.address - OFS_TABLE;
            if (int'(idx) < bcdar_pkg::TABLE_DEPTH) cur_table[idx[7:0]] = a.write_data;
         end else if (a.address >= bcdar_pkg::OFS_OPERAND
                      && a.address <= bcdar_pkg::OFS_OPERAND_LAST) begin
            idx = a.address - bcdar_pkg::OFS_OPERAND;
            cur_operand[idx[2:0]] = a.write_data;
         end
      end else begin
         if (a.address == bcdar_pkg::OFS_KEY) begin
            rd = cur_found;
         end else if (a.address >= bcdar_pkg::OFS_OPERAND
                      && a.address <= bcdar_pkg::OFS_SUM_LAST) begin
            idx = a.address - bcdar_pkg::OFS_OPERAND;
            rd = cur_operand[idx[2:0]];
         end
      end
      return rd;
   endfunction

   task automatic push_access(input logic op, input logic [11:0] addr,
                              input logic [7:0] data);
      access_q.push_back({op, addr, data});
   endtask

   // Mostly valid BCD, with some nines for long carries and some raw bytes
   function automatic logic [7:0] random_operand_byte();
      if ($urandom_range(0, 4) == 0) return 8'($urandom);
      if ($urandom_range(0, 5) == 0) return 8'h99;
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
   endfunction

   task automatic queue_add_run();
      push_access(OP_WRITE, bcdar_pkg::OFS_COMMAND, bcdar_pkg::CMD_ADD);
      for (int k = 0; k < bcdar_pkg::NUM_DIGITS; k++) begin
         // leave the odd operand byte stale
         if ($urandom_range(0, 7) != 0)
            push_access(OP_WRITE, bcdar_pkg::OFS_OPERAND + 12'(k), random_operand_byte());
      end
      push_access(OP_WRITE, bcdar_pkg::OFS_TRIGGER, 8'h00);
      for (int k = 0; k < 3; k++)
         push_access(OP_READ, bcdar_pkg::OFS_OPERAND + 12'(k), 8'($urandom));
      if ($urandom_range(0, 3) == 0)
         push_access(OP_READ, bcdar_pkg::OFS_OPERAND + 12'($urandom_range(3, 7)),
                     8'($urandom));
   endtask

   task automatic queue_search_run();
      logic [7:0] key;
      int         n;
      key = 8'($urandom);
      n   = $urandom_range(0, 6);
      push_access(OP_WRITE, bcdar_pkg::OFS_COMMAND, bcdar_pkg::CMD_SEARCH);
      push_access(OP_WRITE, bcdar_pkg::OFS_KEY, key);
      repeat (n)
         push_access(OP_WRITE,
                     OFS_TABLE + 12'($urandom_range(0, bcdar_pkg::TABLE_DEPTH - 1)),
                     8'($urandom));
      // plant the key somewhere so that matches turn up at every depth
      if ($urandom_range(0, 1) == 0)
         push_access(OP_WRITE,
                     OFS_TABLE + 12'($urandom_range(0, bcdar_pkg::TABLE_DEPTH - 1)), key);
      push_access(OP_WRITE, bcdar_pkg::OFS_TRIGGER, 8'h00);
      push_access(OP_READ, bcdar_pkg::OFS_KEY, 8'($urandom));
   endtask

   task automatic queue_other_command();
      push_access(OP_WRITE, bcdar_pkg::OFS_COMMAND, 8'($urandom_range(2, 255)));
      push_access(OP_WRITE, bcdar_pkg::OFS_TRIGGER,
                  ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00);
      push_access(OP_READ, bcdar_pkg::OFS_OPERAND + 12'($urandom_range(0, 2)), 8'($urandom));
      push_access(OP_READ, bcdar_pkg::OFS_KEY, 8'($urandom));
   endtask

   task automatic queue_noise(input int n);
      logic [11:0] addr;
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: addr = 12'($urandom);
            1: addr = bcdar_pkg::OFS_OPERAND + 12'($urandom_range(0, 7));
            2: addr = OFS_TABLE + 12'($urandom_range(0, 255));
            default: begin
               case ($urandom_range(0, 2))
                  0:       addr = bcdar_pkg::OFS_TRIGGER;
                  1:       addr = bcdar_pkg::OFS_COMMAND;
                  default: addr = bcdar_pkg::OFS_KEY;
               endcase
            end
         endcase
         push_access(1'($urandom), addr, 8'($urandom));
      end
   endtask

   initial begin
      cur_command = 8'h00;
      cur_key     = 8'h00;
      cur_found   = 8'h00;
      for (int k = 0; k < bcdar_pkg::NUM_DIGITS; k++) cur_operand[k] = 8'h00;
      for (int i = 0; i < bcdar_pkg::TABLE_DEPTH; i++) cur_table[i] = 8'h00;

      // Directed: reset reads, add of non-decimal nibbles with overflow,
      // search hitting the last entry, search with no match, trigger with
      // nonzero data, unknown command, unmapped accesses
      push_access(OP_READ, bcdar_pkg::OFS_TRIGGER, 8'hFF);
      push_access(OP_READ, bcdar_pkg::OFS_KEY, 8'h00);
      for (int k = 0; k < bcdar_pkg::NUM_DIGITS; k++)
         push_access(OP_WRITE, bcdar_pkg::OFS_OPERAND + 12'(k), 8'hFF);
      push_access(OP_WRITE, bcdar_pkg::OFS_TRIGGER, 8'h00);
      for (int k = 0; k < 3; k++)
         push_access(OP_READ, bcdar_pkg::OFS_OPERAND + 12'(k), 8'h00);
      push_access(OP_WRITE, bcdar_pkg::OFS_COMMAND, bcdar_pkg::CMD_SEARCH);
      push_access(OP_WRITE, bcdar_pkg::OFS_KEY, 8'hAB);
      push_access(OP_WRITE, 12'hFFF, 8'hAB);
      push_access(OP_WRITE, bcdar_pkg::OFS_TRIGGER, 8'h00);
      push_access(OP_READ, bcdar_pkg::OFS_KEY, 8'h00);
      push_access(OP_WRITE, bcdar_pkg::OFS_KEY, 8'h5A);
      push_access(OP_WRITE, bcdar_pkg::OFS_TRIGGER, 8'h00);
      push_access(OP_READ, bcdar_pkg::OFS_KEY, 8'h00);
      push_access(OP_WRITE, bcdar_pkg::OFS_COMMAND, bcdar_pkg::CMD_ADD);
      push_access(OP_WRITE, bcdar_pkg::OFS_TRIGGER, 8'h80);
      push_access(OP_WRITE, bcdar_pkg::OFS_COMMAND, 8'hFF);
      push_access(OP_WRITE, bcdar_pkg::OFS_TRIGGER, 8'h00);
      push_access(OP_READ, bcdar_pkg::OFS_OPERAND, 8'h00);
      push_access(OP_WRITE, 12'h800, 8'h55);
      push_access(OP_READ, 12'hFFF, 8'h00);
      push_access(OP_READ, bcdar_pkg::OFS_OPERAND_LAST, 8'h00);

      while (access_q.size() < NUM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: queue_add_run();
            4, 5, 6:    queue_search_run();
            7:          queue_other_command();
            default:    queue_noise($urandom_range(1, 8));
         endcase
      end
      total_items = access_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (read_data_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Driver: predict on each transfer, then load the next access after any gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            read_data_q.push_back(predict_read_data({req_opcode, req_address, req_write_data}));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (access_q.size() > 0) begin
               next_access = access_q.pop_front();
               req_valid      <= 1'b1;
               req_opcode     <= next_access.opcode;
               req_address    <= next_access.address;
               req_write_data <= next_access.write_data;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response transfer, then advance the stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (read_data_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual read_data %02h",
                        $time, rsp_read_data);
               error_count++;
            end else begin
               want_data = read_data_q.pop_front();
               if (rsp_read_data !== want_data) begin
                  $display("%0t: read_data mismatch, expected %02h, actual %02h",
                           $time, want_data, rsp_read_data);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (flow_left > 0) begin
            flow_left--;
            stall_next = 1'b0;
         end else begin
            flow_left  = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 24);
            hold_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // Watchdog: drop out when no transfer happens on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: filelist.f
sv/bcdar_pkg.sv
sv/bcdar_table.sv
sv/bcd_add_and_reverse_lookup_regs.sv
bench/tb_bcd_add_and_reverse_lookup_regs.sv
